// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle requires the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/cdd_pkg.sv -----
// ---------------------------------------------------------------------------
// cdd_pkg
// Types, constants and command/status bundles of the CoDel drop decision.
// ---------------------------------------------------------------------------
`default_nettype none

package cdd_pkg;

  // Fraction bits of the reciprocal square root and its alignment in 32 bits.
  localparam int RECIP_BITS = 16;
  localparam int INV_SHIFT  = 32 - RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] INV_MASK = '1;

  // Catch-up iterations allowed for one packet.
  localparam int CATCHUP_MAX = 64;
  localparam int CNT_W       = $clog2(CATCHUP_MAX + 1);

  // 3.0 in the Q32 format of the Newton step.
  localparam logic [63:0] NEWTON_THREE = 64'd3 << 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [63:0] TARGET_RESET   = 64'd5000000;
  localparam logic [63:0] INTERVAL_RESET = 64'd100000000;
  localparam logic [15:0] BACKLOG_RESET  = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET      = 2'd0,
    CFG_INTERVAL    = 2'd1,
    CFG_MIN_BACKLOG = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DECIDE,
    ST_CHECK,
    ST_N_SQ,
    ST_N_MUL,
    ST_N_SUB,
    ST_N_VLO,
    ST_N_VHI,
    ST_N_UPD,
    ST_L_LO,
    ST_L_HI,
    ST_L_UPD,
    ST_OUT
  } cdd_state_t;

  // Operand selection of the shared 32x32 multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_INV_SQ,
    MUL_DROPS_INV2,
    MUL_V_LO,
    MUL_V_HI,
    MUL_IVL_LO,
    MUL_IVL_HI
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    eval;
    logic    leave_drop;
    logic    enter_drop;
    logic    clr_n;
    logic    step_drop;
    mul_op_t mul_op;
    logic    calc_v;
    logic    upd_inv;
    logic    upd_ndt;
    logic    base_now;
    logic    set_last;
    logic    out_load;
  } cdd_cmd_t;

  typedef struct packed {
    logic dropping;
    logic eligible;
    logic restart;
    logic now_ge_ndt;
    logic n_at_max;
  } cdd_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/cdd_if.sv -----
// ---------------------------------------------------------------------------
// cdd_if
// Valid/ready channels for dequeued packets and drop decisions.
// ---------------------------------------------------------------------------
`default_nettype none

interface cdd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] queue_length;
  logic [63:0] enqueue_time;
  logic [63:0] now_time;

  modport source (output valid, output queue_length, output enqueue_time,
                  output now_time, input ready);
  modport sink   (input valid, input queue_length, input enqueue_time,
                  input now_time, output ready);
endinterface

interface cdd_out_if;
  logic        valid;
  logic        ready;
  logic        drop;
  logic [63:0] sojourn;
  logic        in_dropping;
  logic [31:0] drop_count;

  modport source (output valid, output drop, output sojourn, output in_dropping,
                  output drop_count, input ready);
  modport sink   (input valid, input drop, input sojourn, input in_dropping,
                  input drop_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/codel_drop_decision_top.sv -----
// ---------------------------------------------------------------------------
// codel_drop_decision_top
// CoDel drop decision for each dequeued packet, controller plus datapath.
// ---------------------------------------------------------------------------
//
//   Channel   Dir   Handshake      Payload
//   in_ch     in    valid/ready    queue_length, enqueue_time, now_time
//   out_ch    out   valid/ready    drop, sojourn, in_dropping, drop_count
//   cfg_*     in    cfg_we only    cfg_index, cfg_wdata (64 bit)
//
// A packet that does not enter dropping state or stay in it with catch-up
// goes from the decision straight to the output register. Entering dropping
// state runs a control-law step, preceded by a Newton step when the count
// resumes. Each catch-up drop runs one Newton step and one control-law step
// on the single shared 32x32 multiplier, at most 64 of them per packet.
// Reset is synchronous and restores the state and configuration registers.
// A finished result waits in the output register; the next packet is taken
// meanwhile and only its own result waits for the register to empty.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module codel_drop_decision_top import cdd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cdd_in_if.sink                in_ch,
  cdd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Command and status bundles between the sequencer and the datapath.
  cdd_cmd_t    cmd;
  cdd_status_t status;

  // A reported drop is consistent with the reported state.
  logic        drop_ok;

  // The sequencer owns the handshakes; the datapath owns every value.
  cdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cdd_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_queue_length (in_ch.queue_length),
    .in_enqueue_time (in_ch.enqueue_time),
    .in_now_time     (in_ch.now_time),
    .out_drop        (out_ch.drop),
    .out_sojourn     (out_ch.sojourn),
    .out_in_dropping (out_ch.in_dropping),
    .out_drop_count  (out_ch.drop_count)
  );

  assign drop_ok = !out_ch.drop || out_ch.in_dropping;

  // Only one packet is in flight: after a transfer the input stays closed.
  `ASSERT_NEXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken while busy")

  // A packet is only dropped while the block is in dropping state.
  `ASSERT_ALWAYS(a_drop_in_state, !out_ch.valid || drop_ok, "drop outside dropping state")

endmodule

`default_nettype wire

// ----- rtl/core/cdd_dpath.sv -----
// ---------------------------------------------------------------------------
// cdd_dpath
// Registers, shared multiplier and arithmetic of the drop decision.
// ---------------------------------------------------------------------------
`default_nettype none

module cdd_dpath import cdd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cdd_cmd_t              cmd,
  output cdd_status_t           status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [15:0]           in_queue_length,
  input  logic [63:0]           in_enqueue_time,
  input  logic [63:0]           in_now_time,
  output logic                  out_drop,
  output logic [63:0]           out_sojourn,
  output logic                  out_in_dropping,
  output logic [31:0]           out_drop_count
);

  logic [63:0]           target_r;
  logic [63:0]           interval_r;
  logic [15:0]           min_backlog_r;

  logic [63:0]           first_above_r;
  logic [63:0]           ndt_r;
  logic [31:0]           drops_r;
  logic [31:0]           last_drops_r;
  logic                  dropping_r;
  logic [RECIP_BITS-1:0] inv_r;
  logic [CNT_W-1:0]      n_r;

  logic [15:0]           qlen_r;
  logic [63:0]           now_r;
  logic [63:0]           sojourn_r;
  logic                  eligible_r;
  logic [63:0]           prod_r;
  logic [63:0]           lo_r;
  logic [63:0]           v_r;

  logic                  out_drop_r;
  logic [63:0]           out_sojourn_r;
  logic                  out_dropping_r;
  logic [31:0]           out_count_r;

  logic [31:0]           inv32;
  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [63:0]           mul_p;
  logic [63:0]           first_above_nxt;
  logic                  eligible_nxt;
  logic [63:0]           v_nxt;
  logic [63:0]           newton_sum;
  logic [RECIP_BITS-1:0] inv_nxt;
  logic [31:0]           law_step;
  logic [63:0]           ndt_nxt;
  logic [31:0]           delta;

  assign inv32 = 32'(inv_r) << INV_SHIFT;

  always_comb begin
    unique case (cmd.mul_op)
      MUL_INV_SQ:     begin mul_a = inv32;             mul_b = inv32;         end
      MUL_DROPS_INV2: begin mul_a = drops_r;           mul_b = prod_r[63:32]; end
      MUL_V_LO:       begin mul_a = v_r[31:0];         mul_b = inv32;         end
      MUL_V_HI:       begin mul_a = v_r[63:32];        mul_b = inv32;         end
      MUL_IVL_LO:     begin mul_a = interval_r[31:0];  mul_b = inv32;         end
      MUL_IVL_HI:     begin mul_a = interval_r[63:32]; mul_b = inv32;         end
      default:        begin mul_a = '0;                mul_b = '0;            end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Sliding window: a sojourn at or above target for a whole interval qualifies.
  always_comb begin
    first_above_nxt = first_above_r;
    eligible_nxt    = 1'b0;
    if ((sojourn_r < target_r) || (qlen_r <= min_backlog_r)) begin
      first_above_nxt = '0;
    end else if (first_above_r == '0) begin
      first_above_nxt = now_r + interval_r;
    end else if (now_r >= first_above_r) begin
      eligible_nxt = 1'b1;
    end
  end

  // Newton step pieces; the wide product is rebuilt from two 32-bit halves.
  assign v_nxt      = (NEWTON_THREE - prod_r) >> 2;
  assign newton_sum = lo_r + {prod_r[31:0], 32'd0};
  assign inv_nxt    = newton_sum[31+INV_SHIFT +: RECIP_BITS];

  // Control law: upper word of interval * inv, truncated to 32 bits.
  assign law_step = lo_r[63:32] + prod_r[31:0];
  assign ndt_nxt  = (cmd.base_now ? now_r : ndt_r) + 64'(law_step);

  assign delta = drops_r - last_drops_r;

  assign status.dropping   = dropping_r;
  assign status.eligible   = eligible_r;
  assign status.restart    = (delta > 32'd1) && ((now_r - ndt_r) < (interval_r << 4));
  assign status.now_ge_ndt = now_r >= ndt_r;
  assign status.n_at_max   = n_r == CNT_W'(CATCHUP_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r      <= TARGET_RESET;
      interval_r    <= INTERVAL_RESET;
      min_backlog_r <= BACKLOG_RESET;
      first_above_r <= '0;
      ndt_r         <= '0;
      drops_r       <= '0;
      last_drops_r  <= '0;
      dropping_r    <= 1'b0;
      inv_r         <= '0;
      n_r           <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TARGET:      target_r      <= cfg_wdata;
          CFG_INTERVAL:    interval_r    <= cfg_wdata;
          CFG_MIN_BACKLOG: min_backlog_r <= cfg_wdata[15:0];
          default:         ;
        endcase
      end
      if (cmd.eval) begin
        first_above_r <= first_above_nxt;
      end
      if (cmd.leave_drop) begin
        dropping_r <= 1'b0;
      end
      if (cmd.enter_drop) begin
        dropping_r <= 1'b1;
        if (status.restart) begin
          drops_r <= delta;
        end else begin
          drops_r <= 32'd1;
          inv_r   <= INV_MASK;
        end
      end
      if (cmd.clr_n) begin
        n_r <= '0;
      end
      if (cmd.step_drop) begin
        drops_r <= drops_r + 32'd1;
        n_r     <= n_r + CNT_W'(1);
      end
      if (cmd.upd_inv) begin
        inv_r <= inv_nxt;
      end
      if (cmd.upd_ndt) begin
        ndt_r <= ndt_nxt;
      end
      if (cmd.set_last) begin
        last_drops_r <= drops_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qlen_r    <= in_queue_length;
      now_r     <= in_now_time;
      sojourn_r <= in_now_time - in_enqueue_time;
    end
    if (cmd.eval) begin
      eligible_r <= eligible_nxt;
    end
    if (cmd.mul_op != MUL_NONE) begin
      prod_r <= mul_p;
    end
    if ((cmd.mul_op == MUL_V_HI) || (cmd.mul_op == MUL_IVL_HI)) begin
      lo_r <= prod_r;
    end
    if (cmd.calc_v) begin
      v_r <= v_nxt;
    end
    if (cmd.out_load) begin
      out_drop_r     <= eligible_r;
      out_sojourn_r  <= sojourn_r;
      out_dropping_r <= dropping_r;
      out_count_r    <= drops_r;
    end
  end

  assign out_drop        = out_drop_r;
  assign out_sojourn     = out_sojourn_r;
  assign out_in_dropping = out_dropping_r;
  assign out_drop_count  = out_count_r;

endmodule

`default_nettype wire

// ----- rtl/core/cdd_ctrl.sv -----
// ---------------------------------------------------------------------------
// cdd_ctrl
// Sequencer of one packet decision: window check, entry, leaving, catch-up loop.
// ---------------------------------------------------------------------------
`default_nettype none

module cdd_ctrl import cdd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  cdd_status_t status,
  output cdd_cmd_t    cmd
);

  cdd_state_t state_r;
  cdd_state_t state_nxt;
  logic       catchup_r;
  logic       catchup_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      catchup_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      catchup_r   <= catchup_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    catchup_nxt = catchup_r;
    cmd         = '0;
    cmd.mul_op  = MUL_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.dropping) begin
          if (!status.eligible) begin
            cmd.leave_drop = 1'b1;
            state_nxt      = ST_OUT;
          end else begin
            cmd.clr_n   = 1'b1;
            catchup_nxt = 1'b1;
            state_nxt   = ST_CHECK;
          end
        end else if (status.eligible) begin
          cmd.enter_drop = 1'b1;
          catchup_nxt    = 1'b0;
          state_nxt      = status.restart ? ST_N_SQ : ST_L_LO;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_CHECK: begin
        if (status.now_ge_ndt && !status.n_at_max) begin
          cmd.step_drop = 1'b1;
          state_nxt     = ST_N_SQ;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_N_SQ: begin
        cmd.mul_op = MUL_INV_SQ;
        state_nxt  = ST_N_MUL;
      end
      ST_N_MUL: begin
        cmd.mul_op = MUL_DROPS_INV2;
        state_nxt  = ST_N_SUB;
      end
      ST_N_SUB: begin
        cmd.calc_v = 1'b1;
        state_nxt  = ST_N_VLO;
      end
      ST_N_VLO: begin
        cmd.mul_op = MUL_V_LO;
        state_nxt  = ST_N_VHI;
      end
      ST_N_VHI: begin
        cmd.mul_op = MUL_V_HI;
        state_nxt  = ST_N_UPD;
      end
      ST_N_UPD: begin
        cmd.upd_inv = 1'b1;
        state_nxt   = ST_L_LO;
      end
      ST_L_LO: begin
        cmd.mul_op = MUL_IVL_LO;
        state_nxt  = ST_L_HI;
      end
      ST_L_HI: begin
        cmd.mul_op = MUL_IVL_HI;
        state_nxt  = ST_L_UPD;
      end
      ST_L_UPD: begin
        cmd.upd_ndt  = 1'b1;
        cmd.base_now = !catchup_r;
        if (catchup_r) begin
          state_nxt = ST_CHECK;
        end else begin
          cmd.set_last = 1'b1;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CoDel drop decision block. Packets are offered
// on the input channel with random gaps while a local copy of the drop state
// predicts each decision; every result transfer is checked field by field
// against the oldest outstanding prediction. Directed cases at reset values
// and at register extremes come first, then random congestion traffic under
// several register settings, then a long output stall that backs up the block.
// ---------------------------------------------------------------------------

module tb_top;
  import cdd_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 9;
  // Worst case per packet is a capped catch-up plus both sides' gaps.
  // The whole run stays well under this even if many packets hit the cap.
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int TAIL_CYCLES  = 700;
  localparam int REPORT_MAX   = 10;
  localparam int HOLD_CYCLES  = 400;

  // The one index the register port can carry that maps to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // One decision as it leaves the block.
  typedef struct packed {
    logic        drop;
    logic [63:0] sojourn;
    logic        in_dropping;
    logic [31:0] drop_count;
  } decision_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cdd_in_if  in_ch ();
  cdd_out_if out_ch ();

  codel_drop_decision_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Local copy of the registers and of the drop state.
  logic [63:0] target_m;
  logic [63:0] interval_m;
  logic [15:0] backlog_m;
  logic [63:0] first_above_m;
  logic [63:0] next_drop_m;
  logic [31:0] drops_m;
  logic [31:0] last_drops_m;
  logic        dropping_m;
  logic [RECIP_BITS-1:0] recip_m;

  // Decisions predicted at input transfer, waiting for their result transfer.
  decision_t pending_decisions[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  // Both sides stop idling while this is set.
  bit gaps_off       = 1'b0;
  // A nonzero value asks the result side for one long stall.
  int hold_cycles    = 0;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------

  // One Newton step on the reciprocal square root of the drop count. All
  // products wrap at 64 bits, the result keeps RECIP_BITS fraction bits.
  function automatic void refine_recip_sqrt();
    logic [63:0] inv;
    logic [63:0] inv2;
    logic [63:0] v;
    inv = '0;
    inv[INV_SHIFT +: RECIP_BITS] = recip_m;
    inv2 = (inv * inv) >> 32;
    v = NEWTON_THREE - {32'd0, drops_m} * inv2;
    v = v >> 2;
    v = (v * inv) >> 31;
    recip_m = v[INV_SHIFT +: RECIP_BITS];
  endfunction

  // Control law: base + interval / sqrt(count), the step cut to 32 bits.
  function automatic logic [63:0] control_law_next(input logic [63:0] base);
    logic [63:0] scaled;
    logic [63:0] prod;
    scaled = '0;
    scaled[INV_SHIFT +: RECIP_BITS] = recip_m;
    prod = interval_m * scaled;
    return base + {32'd0, prod[63:32]};
  endfunction

  // Drop decision for one dequeued packet; advances the local state.
  function automatic decision_t decide_packet(input logic [15:0] qlen,
                                              input logic [63:0] enq,
                                              input logic [63:0] now);
    decision_t   d;
    logic [63:0] sojourn;
    logic        eligible;
    logic [31:0] growth;
    int          n;
    sojourn  = now - enq;
    eligible = 1'b0;
    if (qlen == 16'd0) first_above_m = '0;

    // A zero marker means the sojourn time is not above target; a window
    // end that wraps to zero just reopens the window on the next packet.
    if (sojourn < target_m || qlen <= backlog_m) begin
      first_above_m = '0;
    end else if (first_above_m == '0) begin
      first_above_m = now + interval_m;
    end else if (now >= first_above_m) begin
      eligible = 1'b1;
    end

    if (dropping_m) begin
      if (!eligible) dropping_m = 1'b0;
      // Catch-up is capped per packet and resumes on the next one.
      n = 0;
      while (dropping_m && now >= next_drop_m && n < CATCHUP_MAX) begin
        drops_m = drops_m + 32'd1;
        refine_recip_sqrt();
        next_drop_m = control_law_next(next_drop_m);
        n++;
      end
    end else if (eligible) begin
      growth     = drops_m - last_drops_m;
      dropping_m = 1'b1;
      drops_m    = 32'd1;
      // Coming back soon after a busy episode resumes at the old growth.
      if (growth > 32'd1 && (now - next_drop_m) < (interval_m << 4)) begin
        drops_m = growth;
        refine_recip_sqrt();
      end else begin
        recip_m = INV_MASK;
      end
      next_drop_m  = control_law_next(now);
      last_drops_m = drops_m;
    end

    d.drop        = eligible;
    d.sojourn     = sojourn;
    d.in_dropping = dropping_m;
    d.drop_count  = drops_m;
    return d;
  endfunction

  // -------------------------------------------------------------------------
  // Channel and register drivers
  // -------------------------------------------------------------------------

  // Offers one packet after a random gap and predicts its decision at the
  // transfer. Valid stays high afterwards so that a zero gap gives
  // back-to-back transfers; a later nonzero gap or wait_idle lowers it.
  task automatic send_packet(input logic [15:0] qlen, input logic [63:0] enq,
                             input logic [63:0] now);
    int gap;
    gap = gaps_off ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.queue_length <= qlen;
    in_ch.enqueue_time <= enq;
    in_ch.now_time     <= now;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_decisions.push_back(decide_packet(qlen, enq, now));
  endtask

  // Stops offering and waits until every predicted decision has come out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_decisions.size() != 0);
  endtask

  // One register write; the enable is left high for a following write.
  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_TARGET:      target_m   = data;
      CFG_INTERVAL:    interval_m = data;
      CFG_MIN_BACKLOG: backlog_m  = data[15:0];
      default: ;
    endcase
  endtask

  // Writes all three registers, optionally preceded by a write to the
  // unmapped index, which must leave everything unchanged.
  task automatic program_regs(input logic [63:0] tgt, input logic [63:0] ivl,
                              input logic [63:0] bl_word, input bit poke_unmapped);
    if (poke_unmapped) cfg_beat(CFG_UNMAPPED, {$urandom, $urandom});
    cfg_beat(CFG_TARGET, tgt);
    cfg_beat(CFG_INTERVAL, ivl);
    cfg_beat(CFG_MIN_BACKLOG, bl_word);
    cfg_we <= 1'b0;
  endtask

  // Packet flow with alternating congested and calm episodes around the
  // current registers. Congested stretches hold the sojourn time above
  // target long enough to open the window and start dropping, with short
  // dips that leave and re-enter. Rare time jumps force long catch-up, and
  // a few fully random packets act as noise.
  task automatic run_flow(input int count);
    logic [63:0] clock_now;
    logic [63:0] soj;
    int unsigned tg;
    int unsigned span;
    int unsigned q;
    int          kind;
    int          pick;
    int          episode_left;
    bit          congested;
    tg           = target_m[31:0];
    span         = interval_m[31:0] / 4 + 1;
    clock_now    = {$urandom, $urandom};
    congested    = 1'b1;
    episode_left = $urandom_range(20, 80);
    for (int i = 0; i < count; i++) begin
      if (episode_left == 0) begin
        congested    = !congested;
        episode_left = $urandom_range(20, 80);
      end
      episode_left--;
      kind = $urandom_range(0, 99);
      if (kind < 3) clock_now += interval_m * 64'($urandom_range(2, 20));
      else clock_now += 64'($urandom_range(1, span));
      if (kind >= 95) begin
        send_packet(16'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
      end else begin
        if (congested && kind % 10 != 0) soj = 64'(tg + $urandom_range(0, 2 * tg));
        else soj = 64'($urandom_range(0, tg - 1));
        pick = $urandom_range(0, 19);
        case (pick)
          0:       q = 0;
          1:       q = 32'(backlog_m);
          default: q = 32'(backlog_m) + 1 + $urandom_range(0, 300);
        endcase
        if (q > 65535) q = 65535;
        send_packet(q[15:0], clock_now - soj, clock_now);
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold when asked for
  // -------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = gaps_off ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
    end
  end

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------
  function automatic void note_mismatch(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("[%0t] %s mismatch: expected %0h, got %0h", $time, field, want, got);
  endfunction

  // Each result transfer is held against the oldest outstanding prediction.
  always @(posedge clk) begin : check_decisions
    decision_t exp_d;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_decisions.size() == 0) begin
        note_mismatch("unexpected result, sojourn", 64'd0, out_ch.sojourn);
      end else begin
        exp_d = pending_decisions.pop_front();
        if (out_ch.drop !== exp_d.drop)
          note_mismatch("drop", 64'(exp_d.drop), 64'(out_ch.drop));
        if (out_ch.sojourn !== exp_d.sojourn)
          note_mismatch("sojourn", exp_d.sojourn, out_ch.sojourn);
        if (out_ch.in_dropping !== exp_d.in_dropping)
          note_mismatch("in_dropping", 64'(exp_d.in_dropping), 64'(out_ch.in_dropping));
        if (out_ch.drop_count !== exp_d.drop_count)
          note_mismatch("drop_count", 64'(exp_d.drop_count), 64'(out_ch.drop_count));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Reset register values: field extremes, the backlog and target
  // boundaries, window opening, entry, catch-up, leaving, re-entry with the
  // count resumed, capped catch-up and a window end that wraps to zero.
  task automatic test_reset_defaults();
    logic [63:0] t;
    send_packet(16'd0, 64'd0, 64'd0);          // empty queue, all zero
    send_packet(16'hFFFF, '1, '1);             // full queue, zero sojourn
    send_packet(16'd1, 64'd0, '1);             // at backlog, largest sojourn
    t = 64'd1000 + TARGET_RESET;
    send_packet(16'd2, 64'd1000, t - 64'd1);   // one below target
    send_packet(16'd2, 64'd1000, t);           // exactly target opens the window
    send_packet(16'd2, 64'd0, t + INTERVAL_RESET - 64'd1);
    t = t + INTERVAL_RESET;
    send_packet(16'd3, t + 64'd1, t);          // wrapped sojourn, window over
    t = t + 64'd300_000_000;
    send_packet(16'd40, t - 64'd6_000_000, t); // a few drops to catch up
    t = t + 64'd10_000_000;
    send_packet(16'd40, t, t);                 // zero sojourn leaves dropping
    t = t + 64'd10_000_000;
    send_packet(16'd9, t - 64'd6_000_000, t);
    t = t + INTERVAL_RESET;
    send_packet(16'd9, t - 64'd6_000_000, t);  // re-entry soon after
    t = t + 64'd1_000_000_000_000;
    send_packet(16'd500, t - 64'd6_000_000, t); // catch-up hits its cap
    send_packet(16'd0, t, t + 64'd5);          // empty queue
    t = 64'd0 - INTERVAL_RESET;
    send_packet(16'd5, t - 64'd6_000_000, t);  // window end wraps to zero
    send_packet(16'd5, t + 64'd5 - 64'd6_000_000, t + 64'd5);
    send_packet(16'd5, 64'd10 - 64'd6_000_000, 64'd10);
    wait_idle();
  endtask

  // Registers at their limits, including masking of the backlog write, the
  // unmapped index and a control law whose step is zero.
  task automatic test_config_extremes();
    logic [63:0] s;
    // Smallest target, largest interval, no backlog needed.
    program_regs(64'd1, '1, 64'd0, 1'b1);
    s = {$urandom, $urandom};
    send_packet(16'd1, s - 64'd1, s);
    send_packet(16'd1, s - 64'd1, s + 64'd2);
    send_packet(16'd0, s, s + 64'd3);
    send_packet(16'hFFFF, s - 64'd9, s + 64'd4);
    wait_idle();
    // Largest target and backlog; the upper write bits must be dropped.
    program_regs('1, 64'd1, {48'hFFFF_FFFF_FFFF, 16'hFFFF}, 1'b0);
    send_packet(16'hFFFF, s + 64'd1, s);
    send_packet(16'hFFFE, 64'd0, '1);
    wait_idle();
    // Backlog of zero written with junk above bit 15. With an interval of
    // one the control-law step is zero, so each catch-up runs the full cap.
    program_regs('1, 64'd1, 64'hDEAD_BEEF_0000_0000, 1'b1);
    s = {$urandom, $urandom};
    send_packet(16'd5, s + 64'd1, s);
    send_packet(16'd5, s + 64'd2, s + 64'd1);
    send_packet(16'd5, s + 64'd3, s + 64'd2);
    send_packet(16'd5, s + 64'd3, s + 64'd2);
    send_packet(16'd0, s, s + 64'd2);
    // Re-entry right away, resuming at a large count.
    send_packet(16'd5, s + 64'd3, s + 64'd2);
    send_packet(16'd5, s + 64'd4, s + 64'd3);
    send_packet(16'd5, s + 64'd5, s + 64'd4);
    wait_idle();
  endtask

  // Random congestion traffic under several register settings, one of them
  // without any idling and one that needs a full queue to count.
  task automatic test_random_traffic();
    logic [63:0] tgt;
    logic [63:0] ivl;
    logic [63:0] bl;
    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        tgt = 64'($urandom_range(1, 50));
        ivl = 64'($urandom_range(64, 1000));
        bl  = 64'd0;
      end else begin
        tgt = 64'($urandom_range(1, 2000));
        ivl = 64'($urandom_range(64, 20000));
        bl  = (p == 5) ? 64'd65534 : 64'($urandom_range(0, 40));
      end
      gaps_off = (p == 2);
      program_regs(tgt, ivl, bl, p == 3);
      run_flow(250);
      wait_idle();
    end
    gaps_off = 1'b0;
  endtask

  // The result side holds off for a long stretch while packets keep coming
  // back to back, so the block fills and stops taking input.
  task automatic test_backpressure();
    program_regs(64'd100, 64'd1000, 64'd2, 1'b0);
    gaps_off    = 1'b1;
    hold_cycles = HOLD_CYCLES;
    run_flow(40);
    wait_idle();
    gaps_off = 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin : run_tests
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.queue_length = '0;
    in_ch.enqueue_time = '0;
    in_ch.now_time     = '0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_TARGET;
    cfg_wdata          = '0;

    // State after reset, as the block starts out.
    target_m      = TARGET_RESET;
    interval_m    = INTERVAL_RESET;
    backlog_m     = BACKLOG_RESET;
    first_above_m = '0;
    next_drop_m   = '0;
    drops_m       = '0;
    last_drops_m  = '0;
    dropping_m    = 1'b0;
    recip_m       = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_config_extremes();
    test_random_traffic();
    test_backpressure();

    // Let anything stray come out before the verdict.
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_decisions.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/cdd_pkg.sv
rtl/core/cdd_if.sv
rtl/core/cdd_dpath.sv
rtl/core/cdd_ctrl.sv
rtl/core/codel_drop_decision_top.sv
test/tb_top.sv
